/* hw/rtl/qtt_pkg.sv */
`timescale 1ns / 1ps
package qtt_pkg;

    localparam int AW = 36;
    localparam int CORE_LAT = 10;

    localparam logic [63:0] HP_NUM = 64'd314159265;
    localparam logic [63:0] HP_DEN = 64'd200000000;

    localparam logic [1:0] REQ_SIN = 2'd0;
    localparam logic [1:0] REQ_COS = 2'd1;
    localparam logic [1:0] REQ_TAN = 2'd2;

    localparam logic [2:0] AXIS_NONE = 3'd0;
    localparam logic [2:0] AXIS_PX   = 3'd1;
    localparam logic [2:0] AXIS_PY   = 3'd2;
    localparam logic [2:0] AXIS_NX   = 3'd3;
    localparam logic [2:0] AXIS_NY   = 3'd4;

    localparam logic [2:0] QUAD_NONE = 3'd0;
    localparam logic [2:0] QUAD_1    = 3'd1;
    localparam logic [2:0] QUAD_2    = 3'd2;
    localparam logic [2:0] QUAD_3    = 3'd3;
    localparam logic [2:0] QUAD_4    = 3'd4;

    localparam logic [1:0] AV_ZERO = 2'd0;
    localparam logic [1:0] AV_POS  = 2'd1;
    localparam logic [1:0] AV_NEG  = 2'd2;

    function automatic logic [63:0] half_pi(input int fb);
        return (HP_NUM * (64'd1 << fb) + (HP_DEN >> 1)) / HP_DEN;
    endfunction

    function automatic logic [2:0] axis_of(input logic signed [AW-1:0] a,
                                           input logic signed [AW-1:0] h,
                                           input logic signed [AW-1:0] t);
        logic [2:0] r;
        r = AXIS_NONE;
        if (a > (h <<< 2) - t || a < t)
            r = AXIS_PX;
        else if (a > h - t && a < h + t)
            r = AXIS_PY;
        else if (a > (h <<< 1) - t && a < (h <<< 1) + t)
            r = AXIS_NX;
        else if (a > (h <<< 1) + h - t && a < (h <<< 1) + h + t)
            r = AXIS_NY;
        return r;
    endfunction

    function automatic logic [2:0] quadrant_of(input logic signed [AW-1:0] a,
                                               input logic signed [AW-1:0] h,
                                               input logic signed [AW-1:0] t);
        logic [2:0] r;
        r = QUAD_NONE;
        if (axis_of(a, h, t) == AXIS_NONE) begin
            if (a > 0 && a < h)
                r = QUAD_1;
            else if (a > h && a < (h <<< 1))
                r = QUAD_2;
            else if (a > (h <<< 1) && a < (h <<< 1) + h)
                r = QUAD_3;
            else if (a > (h <<< 1) + h && a < (h <<< 2))
                r = QUAD_4;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/qtt_sine_core.sv */
`timescale 1ns / 1ps
module qtt_sine_core #(
    parameter int F = 27,
    parameter int R = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [qtt_pkg::AW-1:0] ang,
    input  logic [26:0]                   tol,
    output logic signed [R+1:0]           res
);

    localparam int AW = qtt_pkg::AW;
    localparam int MW = F + 8;
    localparam int TW = MW - 10;
    localparam int D = F - R;
    localparam int MSW = R + 2;
    localparam logic [63:0] H_VAL = qtt_pkg::half_pi(F);
    localparam logic signed [AW-1:0] H = AW'(H_VAL);
    localparam logic [F:0] HF = (F+1)'(H_VAL);
    localparam logic [63:0] M6   = ((64'd1 << (F + 10)) + 64'd5) / 64'd6;
    localparam logic [63:0] M24  = ((64'd1 << (F + 10)) + 64'd23) / 64'd24;
    localparam logic [63:0] M120 = ((64'd1 << (F + 10)) + 64'd119) / 64'd120;
    localparam logic [63:0] M720 = ((64'd1 << (F + 10)) + 64'd719) / 64'd720;

    typedef struct packed {
        logic       sel;
        logic       neg;
        logic       qv;
        logic [1:0] axv;
    } core_ctl_t;

    core_ctl_t               ctl_reg [1:10];
    core_ctl_t               ctl_next;
    core_ctl_t               ctl3_next;
    logic signed [AW-1:0]    c1_ang_reg;
    logic [2:0]              c1_quad_reg;
    logic [F:0]              c2_x_reg;
    logic [F-1:0]            c3_u_reg, c4_u_reg, c5_u_reg, c6_u_reg, c7_u_reg, c8_u_reg;
    logic [F-1:0]            c4_p2_reg, c5_p2_reg, c6_p2_reg, c7_p2_reg, c8_p2_reg;
    logic [F-1:0]            c5_b_reg, c6_b_reg, c7_b_reg;
    logic [F-1:0]            c6_c_reg, c7_c_reg;
    logic [F-1:0]            c7_d_reg;
    logic [TW-1:0]           c8_t1_reg, c8_t2_reg;
    logic [F+1:0]            c9_m_reg;
    logic signed [R+1:0]     c10_res_reg;

    logic signed [AW-1:0]    t_ext;
    logic [2:0]              ax;
    logic [2:0]              quad;
    logic signed [AW-1:0]    x_full;
    logic [F-1:0]            u_next;
    logic [2*F-1:0]          mul1, mul2, mul3, mul4;
    logic [F+MW-1:0]         rcp1, rcp2;
    logic [F+1:0]            m_next;
    logic [MSW-1:0]          mag;
    logic signed [R+1:0]     res_next;

    assign t_ext = $signed({{(AW-27){1'b0}}, tol});
    assign ax = qtt_pkg::axis_of(ang, H, t_ext);
    assign quad = qtt_pkg::quadrant_of(ang, H, t_ext);

    always_comb
    begin
        ctl_next.sel = 1'b0;
        ctl_next.qv = (quad != qtt_pkg::QUAD_NONE);
        ctl_next.neg = (quad == qtt_pkg::QUAD_3) || (quad == qtt_pkg::QUAD_4);
        case (ax)
            qtt_pkg::AXIS_PY: ctl_next.axv = qtt_pkg::AV_POS;
            qtt_pkg::AXIS_NY: ctl_next.axv = qtt_pkg::AV_NEG;
            default:          ctl_next.axv = qtt_pkg::AV_ZERO;
        endcase
    end

    always_comb
    begin
        case (c1_quad_reg)
            qtt_pkg::QUAD_1: x_full = c1_ang_reg;
            qtt_pkg::QUAD_2: x_full = (H <<< 1) - c1_ang_reg;
            qtt_pkg::QUAD_3: x_full = c1_ang_reg - (H <<< 1);
            qtt_pkg::QUAD_4: x_full = (H <<< 2) - c1_ang_reg;
            default:         x_full = '0;
        endcase
    end

    always_comb
    begin
        ctl3_next = ctl_reg[2];
        ctl3_next.sel = !({c2_x_reg, 1'b0} < {1'b0, HF});
    end

    always_comb
    begin
        if ({c2_x_reg, 1'b0} < {1'b0, HF})
            u_next = c2_x_reg[F-1:0];
        else
            u_next = F'(HF - c2_x_reg);
    end

    assign mul1 = (2*F)'(c3_u_reg) * (2*F)'(c3_u_reg);
    assign mul2 = (2*F)'(c4_p2_reg) * (2*F)'(ctl_reg[4].sel ? c4_p2_reg : c4_u_reg);
    assign mul3 = (2*F)'(c5_b_reg) * (2*F)'(ctl_reg[5].sel ? c5_p2_reg : c5_u_reg);
    assign mul4 = (2*F)'(c6_c_reg) * (2*F)'(c6_u_reg);

    assign rcp1 = (F+MW)'(c7_b_reg) * (F+MW)'(ctl_reg[7].sel ? MW'(M24) : MW'(M6));
    assign rcp2 = ctl_reg[7].sel ? (F+MW)'(c7_c_reg) * (F+MW)'(MW'(M720))
                                 : (F+MW)'(c7_d_reg) * (F+MW)'(MW'(M120));

    always_comb
    begin
        if (ctl_reg[8].sel)
            m_next = (F+2)'(1) << F;
        else
            m_next = (F+2)'(c8_u_reg);
        if (ctl_reg[8].sel)
            m_next = m_next - (F+2)'(c8_p2_reg >> 1) + (F+2)'(c8_t1_reg)
                     - (F+2)'(c8_t2_reg);
        else
            m_next = m_next - (F+2)'(c8_t1_reg) + (F+2)'(c8_t2_reg);
    end

    generate
        if (D > 0) begin : g_round
            assign mag = MSW'((c9_m_reg + (F+2)'(1 << (D - 1))) >> D);
        end else begin : g_widen
            assign mag = MSW'(c9_m_reg) << (0 - D);
        end
    endgenerate

    always_comb
    begin
        if (ctl_reg[9].qv)
            res_next = ctl_reg[9].neg ? -$signed(mag) : $signed(mag);
        else if (ctl_reg[9].axv == qtt_pkg::AV_POS)
            res_next = $signed(MSW'(1) << R);
        else if (ctl_reg[9].axv == qtt_pkg::AV_NEG)
            res_next = -$signed(MSW'(1) << R);
        else
            res_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[1] <= ctl_next;
            ctl_reg[2] <= ctl_reg[1];
            ctl_reg[3] <= ctl3_next;
            for (int i = 4; i <= 10; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            c1_ang_reg <= ang;
            c1_quad_reg <= quad;
            c2_x_reg <= x_full[F:0];
            c3_u_reg <= u_next;
            c4_u_reg <= c3_u_reg;
            c4_p2_reg <= mul1[2*F-1:F];
            c5_u_reg <= c4_u_reg;
            c5_p2_reg <= c4_p2_reg;
            c5_b_reg <= mul2[2*F-1:F];
            c6_u_reg <= c5_u_reg;
            c6_p2_reg <= c5_p2_reg;
            c6_b_reg <= c5_b_reg;
            c6_c_reg <= mul3[2*F-1:F];
            c7_u_reg <= c6_u_reg;
            c7_p2_reg <= c6_p2_reg;
            c7_b_reg <= c6_b_reg;
            c7_c_reg <= c6_c_reg;
            c7_d_reg <= mul4[2*F-1:F];
            c8_u_reg <= c7_u_reg;
            c8_p2_reg <= c7_p2_reg;
            c8_t1_reg <= rcp1[F+MW-1:F+10];
            c8_t2_reg <= rcp2[F+MW-1:F+10];
            c9_m_reg <= m_next;
            c10_res_reg <= res_next;
        end
    end

    assign res = c10_res_reg;

endmodule

/* hw/rtl/quadrant_taylor_trig_unit.sv */
`timescale 1ns / 1ps
// Sine, cosine or tangent of a signed fixed-point angle in radians.
// A request enters on in_valid/in_stall with req_type and angle, and its
// result leaves on out_valid/out_stall with value and divide_by_zero.
// Requests are taken when valid is high and stall is low, one per cycle.
// A request passes an input register, the two sine cores, the pipelined
// tangent divider (one quotient bit per stage) and an output register
// before its result is offered.
// Throughput is one request per cycle while out_stall is low.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
// The axis tolerance register is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while no request is in flight, as the block itself does not enforce this.
// Reset clears all valid bits and loads the tolerance with 0.0001 radians.
module quadrant_taylor_trig_unit #(
    parameter int ANGLE_FRAC_BITS = 27,
    parameter int RESULT_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic               divide_by_zero,
    input  logic               cfg_wr_en,
    input  logic [26:0]        cfg_wr_data
);

    localparam int F = ANGLE_FRAC_BITS;
    localparam int R = RESULT_FRAC_BITS;
    localparam int AW = qtt_pkg::AW;
    localparam int LAT = qtt_pkg::CORE_LAT;
    localparam int NW = 2 * R + 1;
    localparam logic signed [AW-1:0] H = AW'(qtt_pkg::half_pi(F));
    localparam logic [26:0] TOL_RST = 27'(((64'd1 << F) + 64'd5000) / 64'd10000);

    typedef struct packed {
        logic       vld;
        logic [1:0] req;
        logic       qz;
        logic [1:0] axc;
        logic       negc;
    } top_ctl_t;

    typedef struct packed {
        logic          vld;
        logic          dv;
        logic          sgn;
        logic          flag;
        logic [31:0]   byp;
        logic [R:0]    den;
        logic [NW-1:0] num;
        logic [R:0]    rem;
        logic [NW-1:0] quo;
    } div_t;

    logic                 adv;
    logic [26:0]          tol_reg;
    top_ctl_t             s1_ctl_reg;
    top_ctl_t             s1_ctl_next;
    logic signed [AW-1:0] s1_ang_reg;
    logic signed [AW-1:0] s1_b_reg;
    logic signed [AW-1:0] s1_b_next;
    top_ctl_t             dl_reg [1:LAT];
    div_t                 dv_reg [0:NW];
    div_t                 dv_next [0:NW];
    logic                 out_valid_reg;
    logic signed [31:0]   value_reg;
    logic signed [31:0]   value_next;
    logic                 dz_reg;

    logic signed [AW-1:0] a_ext;
    logic signed [AW-1:0] t_ext;
    logic [2:0]           ax;
    logic [2:0]           quad;
    logic signed [R+1:0]  sin_res;
    logic signed [R+1:0]  cosb_res;
    logic signed [R+1:0]  c_val;
    logic signed [R+1:0]  abs_s;
    logic signed [R+1:0]  abs_c;
    logic [R+1:0]         rem_ext;
    logic [63:0]          q_ext;

    assign adv = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RST;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    assign a_ext = $signed({{(AW-32){angle[31]}}, angle});
    assign t_ext = $signed({{(AW-27){1'b0}}, tol_reg});
    assign ax = qtt_pkg::axis_of(a_ext, H, t_ext);
    assign quad = qtt_pkg::quadrant_of(a_ext, H, t_ext);

    always_comb
    begin
        s1_ctl_next.vld = in_valid;
        s1_ctl_next.req = req_type;
        s1_ctl_next.qz = (quad == qtt_pkg::QUAD_NONE);
        s1_ctl_next.negc = (quad == qtt_pkg::QUAD_2) || (quad == qtt_pkg::QUAD_4);
        case (ax)
            qtt_pkg::AXIS_PX: s1_ctl_next.axc = qtt_pkg::AV_POS;
            qtt_pkg::AXIS_NX: s1_ctl_next.axc = qtt_pkg::AV_NEG;
            default:          s1_ctl_next.axc = qtt_pkg::AV_ZERO;
        endcase
        case (quad)
            qtt_pkg::QUAD_1: s1_b_next = H - a_ext;
            qtt_pkg::QUAD_2: s1_b_next = (H <<< 1) + H - a_ext;
            qtt_pkg::QUAD_3: s1_b_next = (H <<< 2) + H - a_ext;
            qtt_pkg::QUAD_4: s1_b_next = (H <<< 3) - H - a_ext;
            default:         s1_b_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            for (int i = 1; i <= LAT; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            s1_ctl_reg <= s1_ctl_next;
            dl_reg[1] <= s1_ctl_reg;
            for (int i = 2; i <= LAT; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ang_reg <= a_ext;
            s1_b_reg <= s1_b_next;
        end
    end

    qtt_sine_core #(.F(F), .R(R)) u_core_sin (
        .clk (clk),
        .en  (adv),
        .ang (s1_ang_reg),
        .tol (tol_reg),
        .res (sin_res)
    );

    qtt_sine_core #(.F(F), .R(R)) u_core_cos (
        .clk (clk),
        .en  (adv),
        .ang (s1_b_reg),
        .tol (tol_reg),
        .res (cosb_res)
    );

    always_comb
    begin
        if (!dl_reg[LAT].qz)
            c_val = dl_reg[LAT].negc ? -cosb_res : cosb_res;
        else if (dl_reg[LAT].axc == qtt_pkg::AV_POS)
            c_val = $signed((R+2)'(1) << R);
        else if (dl_reg[LAT].axc == qtt_pkg::AV_NEG)
            c_val = -$signed((R+2)'(1) << R);
        else
            c_val = '0;
        abs_s = (sin_res < 0) ? -sin_res : sin_res;
        abs_c = (c_val < 0) ? -c_val : c_val;

        dv_next[0].vld = dl_reg[LAT].vld;
        dv_next[0].dv = 1'b0;
        dv_next[0].sgn = (sin_res < 0) ^ (c_val < 0);
        dv_next[0].flag = 1'b0;
        dv_next[0].byp = '0;
        dv_next[0].den = abs_c[R:0];
        dv_next[0].num = {abs_s[R:0], {R{1'b0}}};
        dv_next[0].rem = '0;
        dv_next[0].quo = '0;
        case (dl_reg[LAT].req)
            qtt_pkg::REQ_SIN: dv_next[0].byp = 32'(sin_res);
            qtt_pkg::REQ_COS: dv_next[0].byp = 32'(c_val);
            qtt_pkg::REQ_TAN:
            begin
                if (c_val == 0)
                begin
                    dv_next[0].flag = 1'b1;
                    if (sin_res > 0)
                        dv_next[0].byp = 32'h7fffffff;
                    else if (sin_res < 0)
                        dv_next[0].byp = 32'h80000000;
                end
                else
                    dv_next[0].dv = 1'b1;
            end
            default: dv_next[0].byp = '0;
        endcase

        rem_ext = '0;
        for (int i = 1; i <= NW; i++)
        begin
            dv_next[i] = dv_reg[i-1];
            rem_ext = {dv_reg[i-1].rem, dv_reg[i-1].num[NW-1]};
            dv_next[i].num = dv_reg[i-1].num << 1;
            if (rem_ext >= {1'b0, dv_reg[i-1].den})
            begin
                dv_next[i].rem = (R+1)'(rem_ext - {1'b0, dv_reg[i-1].den});
                dv_next[i].quo = {dv_reg[i-1].quo[NW-2:0], 1'b1};
            end
            else
            begin
                dv_next[i].rem = rem_ext[R:0];
                dv_next[i].quo = {dv_reg[i-1].quo[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NW; i++)
            begin
                dv_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i <= NW; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
        end
    end

    assign q_ext = 64'(dv_reg[NW].quo);

    always_comb
    begin
        if (!dv_reg[NW].dv)
            value_next = dv_reg[NW].byp;
        else if (dv_reg[NW].sgn)
        begin
            if (q_ext > 64'h80000000)
                value_next = 32'h80000000;
            else
                value_next = 32'(64'd0 - q_ext);
        end
        else if (q_ext > 64'h7fffffff)
            value_next = 32'h7fffffff;
        else
            value_next = 32'(q_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_reg[NW].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            dz_reg <= dv_reg[NW].flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign value = value_reg;
    assign divide_by_zero = dz_reg;

`ifndef SYNTHESIS
    a_dz_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |->
            value == 32'h7fffffff || value == 32'h80000000 || value == 32'd0)
        else $error("divide_by_zero result is not a saturated or zero value");

    a_valid_from_divider: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(dv_reg[NW].vld))
        else $error("output valid without a request leaving the divider");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[NW].vld && dv_reg[NW].dv |-> dv_reg[NW].rem < dv_reg[NW].den)
        else $error("divider remainder not below divisor");
`endif

endmodule
